>>> src/cube_root_fixed_point_defines.svh
// Assertion macros for the cube root block.
`ifndef CUBE_ROOT_FIXED_POINT_DEFINES_SVH
`define CUBE_ROOT_FIXED_POINT_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define CRR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Always-true invariant, masked during reset.
`define CRR_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

>>> src/crr_pkg.sv
// Shared constants for the cube root pipeline.
`timescale 1ns / 1ps
package crr_pkg;
    // Radicand bits consumed per root bit.
    localparam int DIGIT_BITS = 3;
endpackage

>>> src/crr_ifs.sv
// Valid/ready stream interfaces for radicand and root beats.
`timescale 1ns / 1ps
interface crr_in_if #(
    parameter int IN_BITS = 15
);
    logic               valid;
    logic               ready;
    logic [IN_BITS-1:0] radicand;

    modport source (output valid, output radicand, input ready);
    modport sink   (input valid, input radicand, output ready);
endinterface

interface crr_out_if #(
    parameter int ROOT_BITS = 21
);
    logic                 valid;
    logic                 ready;
    logic [ROOT_BITS-1:0] root_fixed;

    modport source (output valid, output root_fixed, input ready);
    modport sink   (input valid, input root_fixed, output ready);
endinterface

>>> src/crr_stage.sv
// One root-bit step of the cube root recurrence, with its output register.
`timescale 1ns / 1ps
module crr_stage
    import crr_pkg::*;
#(
    parameter int ROOT_BITS = 21
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [ROOT_BITS-1:0]                  i_y,
    input  logic [2*ROOT_BITS+1:0]                i_s3,
    input  logic [ROOT_BITS+1:0]                  i_y3,
    input  logic [2*ROOT_BITS+2:0]                i_rem,
    input  logic [DIGIT_BITS*ROOT_BITS-1:0]       i_t,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [ROOT_BITS-1:0]                  o_y,
    output logic [2*ROOT_BITS+1:0]                o_s3,
    output logic [ROOT_BITS+1:0]                  o_y3,
    output logic [2*ROOT_BITS+2:0]                o_rem,
    output logic [DIGIT_BITS*ROOT_BITS-1:0]       o_t
);
    localparam int T_W   = DIGIT_BITS * ROOT_BITS;
    localparam int S_W   = 2 * ROOT_BITS + 2;
    localparam int Y3_W  = ROOT_BITS + 2;
    localparam int REM_W = 2 * ROOT_BITS + 3;

    logic                 r_valid;
    logic [ROOT_BITS-1:0] r_y;
    logic [S_W-1:0]       r_s3;
    logic [Y3_W-1:0]      r_y3;
    logic [REM_W-1:0]     r_rem;
    logic [T_W-1:0]       r_t;

    logic [REM_W-1:0]     rem_sh;
    logic [S_W-1:0]       s3_dbl;
    logic [Y3_W-1:0]      y3_dbl;
    logic [ROOT_BITS-1:0] y_dbl;
    logic [REM_W-1:0]     trial;
    logic [REM_W:0]       diff;
    logic                 take;

    logic [ROOT_BITS-1:0] n_y;
    logic [S_W-1:0]       n_s3;
    logic [Y3_W-1:0]      n_y3;
    logic [REM_W-1:0]     n_rem;
    logic [T_W-1:0]       n_t;

    // y -> 2y: 3y^2 scales by 4, 3y by 2; trial = 3y^2 + 3y + 1
    always_comb begin
        rem_sh = {i_rem[REM_W-DIGIT_BITS-1:0], i_t[T_W-1 -: DIGIT_BITS]};
        s3_dbl = i_s3 << 2;
        y3_dbl = i_y3 << 1;
        y_dbl  = i_y << 1;
        trial  = REM_W'(s3_dbl) + REM_W'(y3_dbl) + REM_W'(1);
        diff   = {1'b0, rem_sh} - {1'b0, trial};
        take   = ~diff[REM_W];
        // Taking the bit: y -> y+1, so 3y^2 gains 6y+3 and 3y gains 3.
        n_y    = y_dbl | ROOT_BITS'(take);
        n_s3   = take ? (s3_dbl + (S_W'(y3_dbl) << 1) + S_W'(3)) : s3_dbl;
        n_y3   = take ? (y3_dbl + Y3_W'(3)) : y3_dbl;
        n_rem  = take ? diff[REM_W-1:0] : rem_sh;
        n_t    = i_t << DIGIT_BITS;
    end

    assign o_ready = ~r_valid | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_y   <= n_y;
            r_s3  <= n_s3;
            r_y3  <= n_y3;
            r_rem <= n_rem;
            r_t   <= n_t;
        end
    end

    assign o_valid = r_valid;
    assign o_y     = r_y;
    assign o_s3    = r_s3;
    assign o_y3    = r_y3;
    assign o_rem   = r_rem;
    assign o_t     = r_t;
endmodule

>>> src/cube_root_fixed_point.sv
// Pipeline: one register per root bit.
// Throughput: one radicand per cycle while the output is ready; a beat enters whenever its stage is free.
// Output: the last stage register holds the result; stage readies chain combinationally
//   from the output to the input, so bubbles fill while the output waits.
// Reset: synchronous active-low i_rst_n clears every stage valid; data needs no reset.
`timescale 1ns / 1ps
`include "cube_root_fixed_point_defines.svh"
module cube_root_fixed_point
    import crr_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int IN_BITS   = 15
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    crr_in_if.sink    i_in,
    crr_out_if.source o_out
);
    // Root bits: integer part of the cube root of an IN_BITS value, plus fraction.
    localparam int ROOT_BITS = (IN_BITS + 2) / 3 + FRAC_BITS;
    localparam int T_W       = DIGIT_BITS * ROOT_BITS;
    localparam int S_W       = 2 * ROOT_BITS + 2;
    localparam int Y3_W      = ROOT_BITS + 2;
    localparam int REM_W     = 2 * ROOT_BITS + 3;

    // Index k is the input of stage k; index ROOT_BITS is the last stage's register.
    logic                 w_valid [0:ROOT_BITS];
    logic                 w_ready [0:ROOT_BITS];
    logic [ROOT_BITS-1:0] w_y     [0:ROOT_BITS];
    logic [S_W-1:0]       w_s3    [0:ROOT_BITS];
    logic [Y3_W-1:0]      w_y3    [0:ROOT_BITS];
    logic [REM_W-1:0]     w_rem   [0:ROOT_BITS];
    logic [T_W-1:0]       w_t     [0:ROOT_BITS];

    // Target = radicand * 2^(3*FRAC_BITS), consumed three bits per stage from the top.
    // Running state per stage: root y, 3y^2, 3y and the remainder.
    assign w_valid[0] = i_in.valid;
    assign i_in.ready = w_ready[0];
    assign w_y[0]     = '0;
    assign w_s3[0]    = '0;
    assign w_y3[0]    = '0;
    assign w_rem[0]   = '0;
    assign w_t[0]     = T_W'(i_in.radicand) << (DIGIT_BITS * FRAC_BITS);

    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
        crr_stage #(
            .ROOT_BITS (ROOT_BITS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_y     (w_y[k]),
            .i_s3    (w_s3[k]),
            .i_y3    (w_y3[k]),
            .i_rem   (w_rem[k]),
            .i_t     (w_t[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_y     (w_y[k+1]),
            .o_s3    (w_s3[k+1]),
            .o_y3    (w_y3[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_t     (w_t[k+1])
        );
    end

    // The last stage register is the output register.
    assign w_ready[ROOT_BITS] = o_out.ready;
    assign o_out.valid        = w_valid[ROOT_BITS];
    assign o_out.root_fixed   = w_y[ROOT_BITS];

    // Remainder never reaches (y+1)^3 - y^3 = 3y^2 + 3y + 1.
    `CRR_ASSERT_NOW(a_rem_bound, i_clk, i_rst_n, w_valid[ROOT_BITS],
        (S_W+1)'(w_rem[ROOT_BITS]) <= ((S_W+1)'(w_s3[ROOT_BITS]) + (S_W+1)'(w_y3[ROOT_BITS])),
        "cube root remainder out of range")
    // The 3y tracker agrees with the root itself.
    `CRR_ASSERT_NOW(a_y3_track, i_clk, i_rst_n, w_valid[ROOT_BITS],
        w_y3[ROOT_BITS] == (Y3_W'(w_y[ROOT_BITS]) + (Y3_W'(w_y[ROOT_BITS]) << 1)),
        "3y tracker mismatch")
    // Input backpressure only arises from a held output beat.
    `CRR_ASSERT_NOW(a_stall_origin, i_clk, i_rst_n, !i_in.ready,
        o_out.valid && !o_out.ready, "input stalled without output backpressure")
endmodule

>>> tb/sv/tb_cube_root_fixed_point.sv
// Self-checking stream testbench for the fixed-point cube root pipeline.
`timescale 1ns / 1ps
module tb_cube_root_fixed_point;
    import crr_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int IN_BITS     = 15;
    localparam int ROOT_BITS   = (IN_BITS + DIGIT_BITS - 1) / DIGIT_BITS + FRAC_BITS;
    localparam int RAD_MAX     = (1 << IN_BITS) - 1;
    // Pipeline is ROOT_BITS deep; allow some slack after the queue drains.
    localparam int DRAIN_CYCLES = ROOT_BITS + 16;
    // Cycle limit for the whole run; far above what a correct run needs.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_PCT     = 37;

    logic i_clk;
    logic i_rst_n;

    crr_in_if  #(.IN_BITS(IN_BITS))     in_if ();
    crr_out_if #(.ROOT_BITS(ROOT_BITS)) out_if ();

    cube_root_fixed_point #(
        .FRAC_BITS(FRAC_BITS),
        .IN_BITS  (IN_BITS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // Roots still in flight, oldest first.
    logic [ROOT_BITS-1:0] root_expect_q[$];
    int                   mismatch_count = 0;
    int                   cycle_count    = 0;
    // When set, neither side idles: a full-rate stretch.
    bit                   full_rate      = 1'b0;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Floored root: largest r with r^3 <= x * 2^(3*FRAC_BITS), found bit by bit from the top.
    function automatic logic [ROOT_BITS-1:0] floor_cube_root(input logic [IN_BITS-1:0] x);
        logic [127:0]         target;
        logic [127:0]         cand_w;
        logic [127:0]         cube;
        logic [ROOT_BITS-1:0] root;
        logic [ROOT_BITS-1:0] cand;
        target = 128'(x) << (3 * FRAC_BITS);
        root   = '0;
        for (int b = ROOT_BITS - 1; b >= 0; b--) begin
            cand   = root | (ROOT_BITS'(1) << b);
            cand_w = 128'(cand);
            cube   = cand_w * cand_w * cand_w;
            if (cube <= target) begin
                root = cand;
            end
        end
        return root;
    endfunction

    // Drive one radicand beat; valid stays high on return so back-to-back beats need no dip.
    task automatic send_radicand(input logic [IN_BITS-1:0] value);
        while (!full_rate && ($urandom_range(99) < IDLE_PCT)) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.radicand <= value;
        do begin
            @(posedge i_clk);
        end while (!in_if.ready);
        // Accepted at this edge.
        root_expect_q.push_back(floor_cube_root(value));
    endtask

    // Zero, max, perfect cubes and their neighbors, bit patterns.
    task automatic test_directed_corners();
        int corner_vals[$];
        corner_vals = '{0, 1, 2, 7, 8, 9, 26, 27, 28, 63, 64, 65, 999, 1000, 1001,
                        15'h5555, 15'h2AAA, 15'h4000, 15'h3FFF, 27000, 29791, 29792,
                        RAD_MAX - 1, RAD_MAX};
        foreach (corner_vals[i]) begin
            send_radicand(IN_BITS'(corner_vals[i]));
        end
    endtask

    function automatic logic [IN_BITS-1:0] pick_radicand();
        int unsigned sel;
        int unsigned k;
        sel = $urandom_range(9);
        k   = $urandom_range(31, 1);
        case (sel)
            5: begin
                pick_radicand = IN_BITS'($urandom_range(63));
            end
            6: begin
                pick_radicand = IN_BITS'(RAD_MAX - $urandom_range(63));
            end
            7: begin
                pick_radicand = IN_BITS'(k * k * k);
            end
            8: begin
                // Either side of a perfect cube, where flooring is tightest.
                pick_radicand = $urandom_range(1) ? IN_BITS'(k * k * k - 1)
                                                  : IN_BITS'(k * k * k + 1);
            end
            9: begin
                pick_radicand = IN_BITS'(1) << $urandom_range(IN_BITS - 1);
                if ($urandom_range(1)) begin
                    pick_radicand = ~pick_radicand;
                end
            end
            default: begin
                pick_radicand = IN_BITS'($urandom_range(RAD_MAX));
            end
        endcase
    endfunction

    // Back-to-back beats with the sink always ready: pipeline stays full.
    task automatic test_full_rate_stream(input int n_beats);
        full_rate = 1'b1;
        repeat (n_beats) send_radicand(pick_radicand());
        full_rate = 1'b0;
    endtask

    // Random gaps on the source and random stalls on the sink.
    task automatic test_random_radicands(input int n_beats);
        repeat (n_beats) send_radicand(pick_radicand());
    endtask

    // Sink side: random backpressure, off during full-rate stretches.
    always @(posedge i_clk) begin
        out_if.ready <= full_rate || ($urandom_range(99) >= IDLE_PCT);
    end

    // Result checker: every accepted root beat against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (root_expect_q.size() == 0) begin
                $error("root_fixed: unexpected beat, expected none, actual %0d",
                       out_if.root_fixed);
                mismatch_count++;
            end else begin
                logic [ROOT_BITS-1:0] want;
                want = root_expect_q.pop_front();
                if (out_if.root_fixed !== want) begin
                    $error("root_fixed: expected %0d, actual %0d", want, out_if.root_fixed);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.radicand = '0;
        out_if.ready   = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        test_full_rate_stream(500);
        test_random_radicands(1250);

        in_if.valid <= 1'b0;
        while (root_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

>>> cube_root_fixed_point.f
+incdir+src
src/crr_pkg.sv
src/crr_ifs.sv
src/crr_stage.sv
src/cube_root_fixed_point.sv
tb/sv/tb_cube_root_fixed_point.sv
